// ----- rtl/core/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants for the single-wire bus master
// Phase and command codes, configuration register map and reset values.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int CFG_WIDTH   = 10;
   localparam int NUM_CFG     = 8;
   localparam int CSR_IDX_W   = 4;

   typedef logic [1:0]           mode_type;
   typedef logic [7:0]           byte_type;
   typedef logic [CFG_WIDTH-1:0] cfg_word_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef cfg_word_type [NUM_CFG-1:0] cfg_array_type;

   // command codes carried in mode
   localparam mode_type OP_NONE  = 2'd0;
   localparam mode_type OP_RESET = 2'd1;
   localparam mode_type OP_WRITE = 2'd2;
   localparam mode_type OP_READ  = 2'd3;

   // sequencer phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LOW  = 2'd1;
   localparam logic [1:0] PH_WAIT = 2'd2;
   localparam logic [1:0] PH_TAIL = 2'd3;

   // register map
   localparam int REG_RESET_LOW     = 0;
   localparam int REG_PRESENCE_WAIT = 1;
   localparam int REG_RESET_TAIL    = 2;
   localparam int REG_SLOT_LOW      = 3;
   localparam int REG_READ_SAMPLE   = 4;
   localparam int REG_READ_TAIL     = 5;
   localparam int REG_WRITE_HOLD    = 6;
   localparam int REG_WRITE_RECOVER = 7;

   localparam cfg_array_type CFG_RESET_VALS = {
      10'd1,   // write recovery
      10'd58,  // write hold
      10'd49,  // read tail
      10'd10,  // read sample
      10'd2,   // slot low
      10'd380, // reset tail
      10'd100, // presence wait
      10'd480  // reset low
   };

endpackage

// ----- rtl/core/one_wire_bus_master_core.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_core: single-wire bus master sequencer
//
// Every req beat is one timing tick: it carries the sampled bus level and an
// optional command (reset/presence, write byte, read byte). Commands are
// taken only while idle; while busy the command field is ignored. Each
// req beat yields exactly one rsp beat with the pin drive, busy, a one-tick
// done pulse, the last presence result and the last received byte.
// The rsp beat is registered and is presented in the cycle after the
// req beat. Throughput is one tick per cycle; the whole tick update is a
// single pass of logic from the state registers to the result register.
// When the receiver stalls, the result register holds and req_ready drops
// until the pending beat is taken; it is high again in the cycle the rsp
// beat leaves, so a tick can enter in every cycle.
// Slot timings live in eight csr registers (10 bits each), written through
// csr_write_en / csr_index / csr_wdata; indexes beyond seven are dropped.
// Synchronous reset puts the sequencer in idle, clears presence and the
// received byte, empties the result register and restores the timing
// registers to their defaults.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   // tick channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  owbm_pkg::mode_type     req_mode,
   input  owbm_pkg::byte_type     req_tx_byte,
   input  logic                   req_pin_level,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_drive_enable,
   output logic                   rsp_drive_level,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic                   rsp_presence,
   output owbm_pkg::byte_type     rsp_rx_byte,
   // configuration
   input  logic                   csr_write_en,
   input  owbm_pkg::csr_index_type csr_index,
   input  owbm_pkg::cfg_word_type csr_wdata
);
   import owbm_pkg::*;

   localparam int LEN_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam logic [LEN_W-1:0] MAX_COUNT = LEN_W'((64'd1 << COUNT_WIDTH) - 64'd1);

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [LEN_W-1:0]       len_type;

   // saturate a register value to the counter range, with an optional floor of one
   function automatic len_type clamp_len(input cfg_word_type v, input logic min_one);
      len_type x;
      x = LEN_W'(v);
      if (min_one && (x == '0)) begin
         x = LEN_W'(1);
      end
      if (x > MAX_COUNT) begin
         x = MAX_COUNT;
      end
      return x;
   endfunction

   function automatic len_type phase_len(input logic [1:0] ph, input mode_type op,
                                         input cfg_array_type c);
      len_type l;
      l = '0;
      unique case (ph)
         PH_LOW: begin
            l = clamp_len((op == OP_RESET) ? c[REG_RESET_LOW] : c[REG_SLOT_LOW], 1'b1);
         end
         PH_WAIT: begin
            if (op == OP_RESET) begin
               l = clamp_len(c[REG_PRESENCE_WAIT], 1'b1);
            end else if (op == OP_READ) begin
               l = clamp_len(c[REG_READ_SAMPLE], 1'b1);
            end else begin
               l = clamp_len(c[REG_WRITE_HOLD], 1'b1);
            end
         end
         PH_TAIL: begin
            if (op == OP_RESET) begin
               l = clamp_len(c[REG_RESET_TAIL], 1'b0);
            end else if (op == OP_READ) begin
               l = clamp_len(c[REG_READ_TAIL], 1'b0);
            end else begin
               l = clamp_len(c[REG_WRITE_RECOVER], 1'b0);
            end
         end
         default: l = '0;
      endcase
      return l;
   endfunction

   // configuration registers
   cfg_array_type cfg_ff;

   // sequencer state
   logic [1:0] phase_ff, phase_in;
   mode_type   op_ff, op_in;
   count_type  tick_ff, tick_in;
   logic [2:0] bit_ff, bit_in;
   byte_type   shift_ff, shift_in;
   logic       pres_ff, pres_in;
   byte_type   rxb_ff, rxb_in;
   logic       done_in;

   // result register
   logic       rsp_valid_ff;
   logic       drv_en_ff, drv_en_in;
   logic       drv_lvl_ff, drv_lvl_in;
   logic       busy_ff, done_ff;

   logic       req_fire;
   len_type    cur_len;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET_VALS;
      end else if (csr_write_en && (csr_index < CSR_IDX_W'(NUM_CFG))) begin
         cfg_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   // one tick: count, then leave at most two phases (wait, then a zero tail)
   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      rxb_in   = rxb_ff;
      done_in  = 1'b0;
      cur_len  = '0;
      if (phase_ff == PH_IDLE) begin
         if (req_mode != OP_NONE) begin
            op_in    = req_mode;
            phase_in = PH_LOW;
            tick_in  = '0;
            bit_in   = '0;
            shift_in = (req_mode == OP_WRITE) ? req_tx_byte : '0;
         end
      end else begin
         tick_in = tick_ff + COUNT_WIDTH'(1);
         for (int k = 0; k < 3; k++) begin
            cur_len = phase_len(phase_in, op_in, cfg_ff);
            if ((phase_in != PH_IDLE) && (LEN_W'(tick_in) >= cur_len)) begin
               case (phase_in)
                  PH_LOW: begin
                     phase_in = PH_WAIT;
                     tick_in  = '0;
                  end
                  PH_WAIT: begin
                     if (op_in == OP_RESET) begin
                        pres_in = !req_pin_level;
                     end else if (op_in == OP_READ) begin
                        shift_in = {req_pin_level, shift_in[7:1]};
                     end else begin
                        shift_in = {1'b0, shift_in[7:1]};
                     end
                     phase_in = PH_TAIL;
                     tick_in  = '0;
                  end
                  PH_TAIL: begin
                     if ((op_in == OP_RESET) || (bit_in == 3'd7)) begin
                        if (op_in == OP_READ) begin
                           rxb_in = shift_in;
                        end
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end else begin
                        bit_in   = bit_in + 3'd1;
                        phase_in = PH_LOW;
                        tick_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
      drv_en_in  = (phase_in == PH_LOW) || ((phase_in == PH_WAIT) && (op_in == OP_WRITE));
      drv_lvl_in = (phase_in == PH_WAIT) && (op_in == OP_WRITE) && shift_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= OP_NONE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
         rxb_ff   <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
         rxb_ff   <= rxb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         drv_en_ff  <= drv_en_in;
         drv_lvl_ff <= drv_lvl_in;
         busy_ff    <= (phase_in != PH_IDLE);
         done_ff    <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_enable = drv_en_ff;
   assign rsp_drive_level  = drv_lvl_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_presence     = pres_ff;
   assign rsp_rx_byte      = rxb_ff;

   // done beat never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done beat reports busy");

   // a high level is only ever driven
   a_level_driven: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_level) |-> rsp_drive_enable)
      else $error("drive level without enable");

   // a plain tick while idle leaves the sequencer idle
   a_idle_stays: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (phase_ff == PH_IDLE) && (req_mode == OP_NONE))
         |=> (phase_ff == PH_IDLE) && rsp_valid && !rsp_busy_res && !rsp_done_res)
      else $error("idle tick started an operation");

   // a tick taken while busy reports busy or done
   a_busy_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (phase_ff != PH_IDLE)) |=> (rsp_valid && (rsp_busy_res || rsp_done_res)))
      else $error("busy tick lost its status");

endmodule
